>>> src/psc_pkg.sv
`timescale 1ns / 1ps

package psc_pkg;

	localparam int COUNT_BITS  = 24;
	localparam int THRESH_W    = 10;
	localparam int FRAC_BITS   = 16;
	localparam int SIM_W       = FRAC_BITS + 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX      = '1;
	localparam logic [THRESH_W-1:0]   THRESH_RESET   = THRESH_W'(1);
	localparam logic [SIM_W-1:0]      SIM_ONE        = SIM_W'(1) << FRAC_BITS;
	localparam logic                  REG_MATCH_THRESHOLD = 1'b0;

	typedef struct packed {
		logic [7:0] first_red;
		logic [7:0] first_green;
		logic [7:0] first_blue;
		logic [7:0] second_red;
		logic [7:0] second_green;
		logic [7:0] second_blue;
		logic       final_pixel;
	} pix_in_t;

	typedef struct packed {
		logic             pixel_differs;
		logic [SIM_W-1:0] similarity;
		logic             image_done;
	} pix_out_t;

	typedef struct packed {
		logic                  differs;
		logic                  last;
		logic [COUNT_BITS-1:0] same_total;
		logic [COUNT_BITS-1:0] pixel_total;
	} psc_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} psc_qstat_t;

endpackage

>>> src/psc_front.sv
`timescale 1ns / 1ps

module psc_front
	import psc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pix_in_t             in_data,
	input  logic [THRESH_W-1:0] match_threshold,
	input  psc_qstat_t          qstat,
	output logic                push,
	output psc_entry_t          push_entry
);

	logic [COUNT_BITS-1:0] same_total_q;
	logic [COUNT_BITS-1:0] pixel_total_q;
	logic [COUNT_BITS-1:0] same_next;
	logic [COUNT_BITS-1:0] pixel_next;
	logic [7:0]            d_red;
	logic [7:0]            d_green;
	logic [7:0]            d_blue;
	logic [THRESH_W-1:0]   sad;
	logic                  same;

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	assign in_stall = qstat.full;
	assign push     = in_valid && !qstat.full;

	always_comb begin
		d_red      = abs_diff(in_data.first_red, in_data.second_red);
		d_green    = abs_diff(in_data.first_green, in_data.second_green);
		d_blue     = abs_diff(in_data.first_blue, in_data.second_blue);
		sad        = THRESH_W'(d_red) + THRESH_W'(d_green) + THRESH_W'(d_blue);
		same       = sad < match_threshold;
		pixel_next = (pixel_total_q == COUNT_MAX) ? COUNT_MAX : pixel_total_q + 1'b1;
		same_next  = same_total_q;
		if (same && same_total_q != COUNT_MAX) begin
			same_next = same_total_q + 1'b1;
		end
		push_entry.differs     = !same;
		push_entry.last        = in_data.final_pixel;
		push_entry.same_total  = same_next;
		push_entry.pixel_total = pixel_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			same_total_q  <= '0;
			pixel_total_q <= '0;
		end else if (push) begin
			if (in_data.final_pixel) begin
				same_total_q  <= '0;
				pixel_total_q <= '0;
			end else begin
				same_total_q  <= same_next;
				pixel_total_q <= pixel_next;
			end
		end
	end

endmodule

>>> src/psc_queue.sv
`timescale 1ns / 1ps

module psc_queue
	import psc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  psc_entry_t push_entry,
	input  logic       pop,
	output psc_entry_t head,
	output psc_qstat_t qstat
);

	psc_entry_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head        = mem_q[rd_ptr_q];
	assign qstat.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> src/psc_back.sv
`timescale 1ns / 1ps

module psc_back
	import psc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  psc_qstat_t qstat,
	input  psc_entry_t head,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output pix_out_t   out_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	localparam int CNT_W = $clog2(SIM_W);

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  out_valid_q;
	pix_out_t              out_data_q;
	logic [COUNT_BITS:0]   rem_q;
	logic [COUNT_BITS-1:0] div_q;
	logic [SIM_W-1:0]      quo_q;
	logic                  differs_q;
	logic                  out_free;
	logic [COUNT_BITS+1:0] trial;
	logic                  ge;
	logic [COUNT_BITS:0]   rem_next;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = (state_q == ST_IDLE) && !qstat.empty && out_free;

	always_comb begin
		trial    = {1'b0, rem_q} - {2'b00, div_q};
		ge       = !trial[COUNT_BITS+1];
		rem_next = ge ? trial[COUNT_BITS:0] : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						if (head.last) begin
							state_q <= ST_DIV;
							cnt_q   <= '0;
						end else begin
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SIM_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					differs_q <= head.differs;
					rem_q     <= {1'b0, head.same_total};
					div_q     <= head.pixel_total;
					quo_q     <= '0;
					if (!head.last) begin
						out_data_q.pixel_differs <= head.differs;
						out_data_q.similarity    <= '0;
						out_data_q.image_done    <= 1'b0;
					end
				end
			end
			ST_DIV: begin
				rem_q <= {rem_next[COUNT_BITS-1:0], 1'b0};
				quo_q <= {quo_q[SIM_W-2:0], ge};
			end
			ST_DONE: begin
				if (out_free) begin
					out_data_q.pixel_differs <= differs_q;
					out_data_q.similarity    <= quo_q;
					out_data_q.image_done    <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> src/pixel_similarity_counter.sv
`timescale 1ns / 1ps

// channel  direction  payload    handshake
// in       input      pix_in_t   in_valid / in_stall
// out      output     pix_out_t  out_valid / out_stall
// cfg      input      APB        psel / penable / pwrite / pready
//
// A pixel pair is taken each cycle while the four-entry queue has room.
// A plain pair moves from the queue head to the output register when that is free.
// A final pair runs a restoring divider, one quotient bit a cycle: it leaves once all
// quotient bits are in and the output is free, and the next entry is taken after that.
// Reset clears the counters, the queue and the output valid; threshold resets to 1.
// Output stall holds the result register; input stall rises only on a full queue.

module pixel_similarity_counter
	import psc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  pix_in_t            in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output pix_out_t           out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [THRESH_W-1:0] threshold_q;
	logic                push;
	logic                pop;
	psc_entry_t          push_entry;
	psc_entry_t          head;
	psc_qstat_t          qstat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MATCH_THRESHOLD) ? PDATA_W'(threshold_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESH_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == REG_MATCH_THRESHOLD) begin
			threshold_q <= pwdata[THRESH_W-1:0];
		end
	end

	psc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.match_threshold (threshold_q),
		.qstat           (qstat),
		.push            (push),
		.push_entry      (push_entry)
	);

	psc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	psc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	a_sim_zero_mid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.image_done |-> out_data.similarity == '0)
		else $error("similarity nonzero on a non-final result");

	a_sim_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.similarity <= SIM_ONE)
		else $error("similarity above one");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> !push || pop)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

endmodule
